>>> sv/keypad_code_lock_core_assert.svh
// Assertion macros for the keypad code lock core.
// Used by the top level; the macros assume signals named clk and arst_n in scope.
`ifndef KEYPAD_CODE_LOCK_CORE_ASSERT_SVH
`define KEYPAD_CODE_LOCK_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define KCL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define KCL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/kcl_pkg.sv
// Shared constants and types for the keypad code lock core.
// No dependencies; every other file but the assertion header imports this package.
package kcl_pkg;

	localparam int MAX_KEYS_DEF = 14;
	localparam int PW_BYTES     = 14;
	localparam int KEY_W        = 8;
	localparam int CNT_W        = 4;
	localparam int HEAD_W       = 64;
	localparam int TAIL_W       = 48;
	localparam int CFG_W        = 64;
	localparam int CFG_IDX_W    = 2;

	localparam logic [KEY_W-1:0] KEY_NONE  = 8'd0;
	localparam logic [KEY_W-1:0] KEY_ENTER = 8'd35;

	localparam logic [CFG_IDX_W-1:0] CFG_HEAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TAIL = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd2;

	// "1234" with the first character in the low byte
	localparam logic [HEAD_W-1:0] PW_HEAD_RST = 64'h0000_0000_3433_3231;
	localparam logic [TAIL_W-1:0] PW_TAIL_RST = '0;
	localparam logic [CNT_W-1:0]  PW_LEN_RST  = 4'd4;

	typedef enum logic [2:0] {
		ST_IGNORED  = 3'd0,
		ST_STORED   = 3'd1,
		ST_CORRECT  = 3'd2,
		ST_WRONG    = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	typedef struct packed {
		logic [PW_BYTES-1:0][KEY_W-1:0] bytes;
		logic [CNT_W-1:0]               len;
	} pw_cfg_t;

	typedef struct packed {
		status_t          status;
		logic [CNT_W-1:0] entry_count;
		logic             unlocked;
		logic             enter_seen;
	} res_t;

endpackage

>>> sv/kcl_if.sv
// Valid/ready channel interfaces for the keypad code lock core.
// Depends on kcl_pkg for payload widths and the status type.
interface kcl_key_if;
	import kcl_pkg::*;

	logic             valid;
	logic             ready;
	logic [KEY_W-1:0] key_code;

	modport source (output valid, output key_code, input ready);
	modport sink (input valid, input key_code, output ready);
endinterface

interface kcl_res_if;
	import kcl_pkg::*;

	logic             valid;
	logic             ready;
	status_t          status;
	logic [CNT_W-1:0] entry_count;
	logic             unlocked;
	logic             enter_seen;

	modport source (output valid, output status, output entry_count, output unlocked,
		output enter_seen, input ready);
	modport sink (input valid, input status, input entry_count, input unlocked,
		input enter_seen, output ready);
endinterface

>>> sv/kcl_cfg.sv
// Password register file of the keypad code lock core.
// Depends on kcl_pkg; raises a clear pulse on every write to a known register.
module kcl_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0] index,
	input  logic [kcl_pkg::CFG_W-1:0]     wdata,
	output kcl_pkg::pw_cfg_t              pw,
	output logic                          clear
);
	import kcl_pkg::*;

	logic [HEAD_W-1:0] head_q;
	logic [TAIL_W-1:0] tail_q;
	logic [CNT_W-1:0]  len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= PW_HEAD_RST;
			tail_q <= PW_TAIL_RST;
			len_q  <= PW_LEN_RST;
		end else if (we) begin
			unique case (index)
				CFG_HEAD: head_q <= wdata[HEAD_W-1:0];
				CFG_TAIL: tail_q <= wdata[TAIL_W-1:0];
				CFG_LEN:  len_q  <= wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign clear    = we && (index == CFG_HEAD || index == CFG_TAIL || index == CFG_LEN);
	assign pw.bytes = {tail_q, head_q};
	assign pw.len   = len_q;
endmodule

>>> sv/kcl_in_stage.sv
// Input register of the keypad code lock core.
// Depends on kcl_pkg and kcl_if; holds one key request until the lock stage takes it.
module kcl_in_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	kcl_key_if.sink                   keys,
	input  logic                      advance,
	output logic                      valid_s1,
	output logic [kcl_pkg::KEY_W-1:0] key_s1
);
	import kcl_pkg::*;

	logic take;

	assign keys.ready = !valid_s1 || advance;
	assign take       = keys.valid && keys.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			key_s1 <= keys.key_code;
		end
	end
endmodule

>>> sv/kcl_lock.sv
// Entry store, password compare and lock flags of the keypad code lock core.
// Depends on kcl_pkg; decides one key per step and presents its result.
module kcl_lock #(
	parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      step,
	input  logic [kcl_pkg::KEY_W-1:0] key_s1,
	input  kcl_pkg::pw_cfg_t          pw,
	output kcl_pkg::res_t             res
);
	import kcl_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_KEYS);

	logic [MAX_KEYS-1:0][KEY_W-1:0] entry_store_q;
	logic [CNT_W-1:0]               entry_len_q;
	logic                           unlock_q;
	logic                           enter_q;

	logic [MAX_KEYS-1:0] byte_ok;
	logic                match;
	logic                append;
	logic [CNT_W-1:0]    len_nxt;
	logic                unlock_nxt;
	logic                enter_nxt;
	status_t             status_nxt;

	// Only bytes below the password length take part in the compare.
	always_comb begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			byte_ok[i] = (CNT_W'(i) >= pw.len) || (entry_store_q[i] == pw.bytes[i]);
		end
	end

	assign match = (pw.len == entry_len_q) && (&byte_ok);

	always_comb begin
		len_nxt    = entry_len_q;
		unlock_nxt = unlock_q;
		enter_nxt  = enter_q;
		append     = 1'b0;
		priority if (key_s1 == KEY_ENTER) begin
			enter_nxt = 1'b1;
			len_nxt   = '0;
			if (match) begin
				unlock_nxt = 1'b1;
				status_nxt = ST_CORRECT;
			end else begin
				status_nxt = ST_WRONG;
			end
		end else if (key_s1 == KEY_NONE) begin
			status_nxt = ST_IGNORED;
		end else if (entry_len_q < MAX_CNT) begin
			append     = 1'b1;
			len_nxt    = entry_len_q + CNT_W'(1);
			status_nxt = ST_STORED;
		end else begin
			len_nxt    = '0;
			status_nxt = ST_OVERFLOW;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_len_q <= '0;
			unlock_q    <= 1'b0;
			enter_q     <= 1'b0;
		end else if (clear) begin
			entry_len_q <= '0;
			unlock_q    <= 1'b0;
		end else if (step) begin
			entry_len_q <= len_nxt;
			unlock_q    <= unlock_nxt;
			enter_q     <= enter_nxt;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_KEYS; i++) begin
			if (step && append && entry_len_q == CNT_W'(i)) begin
				entry_store_q[i] <= key_s1;
			end
		end
	end

	assign res.status      = status_nxt;
	assign res.entry_count = len_nxt;
	assign res.unlocked    = unlock_nxt;
	assign res.enter_seen  = enter_nxt;
endmodule

>>> sv/kcl_out_stage.sv
// Result register of the keypad code lock core.
// Depends on kcl_pkg and kcl_if; holds one result until the receiver takes it.
module kcl_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  kcl_pkg::res_t res,
	output logic          free,
	kcl_res_if.source     results
);
	import kcl_pkg::*;

	logic valid_q;
	res_t res_q;

	assign free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign results.valid       = valid_q;
	assign results.status      = res_q.status;
	assign results.entry_count = res_q.entry_count;
	assign results.unlocked    = res_q.unlocked;
	assign results.enter_seen  = res_q.enter_seen;
endmodule

>>> sv/keypad_code_lock_core.sv
// Keypad code lock core: one key request per cycle unless stalled; one result per key.
// Channels: keys (sink, key_code) and results (source, status, entry_count,
//   unlocked, enter_seen), both valid/ready; a request moves when both are high.
// Each key request yields exactly one result, in order.
// Path: a taken key sits in the input register, is decided combinationally and lands
//   in the result register; results.valid rises when that register loads.
// Throughput: one key per cycle while results.ready stays high; the entry is compared
//   against all password bytes in parallel between the two registers.
// Stall: when results.ready is low the result register holds, the input register
//   fills once more, then keys.ready drops; nothing is lost or repeated.
// Configuration: cfg_we with cfg_index 0/1/2 writes password head, tail, length;
//   a write to a known register clears the entry and the unlocked flag. Write only
//   while no request is in flight. Index 3 is ignored.
// Reset (arst_n low): password "1234", entry empty, both flags low, no result pending.
//   The entry store is not cleared; only bytes below the password length are compared.
`include "keypad_code_lock_core_assert.svh"

module keypad_code_lock_core #(
	parameter int MAX_KEYS = kcl_pkg::MAX_KEYS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [kcl_pkg::CFG_W-1:0]     cfg_wdata,
	kcl_key_if.sink                       keys,
	kcl_res_if.source                     results
);
	import kcl_pkg::*;

	pw_cfg_t          pw;
	logic             cfg_clear;
	logic             valid_s1;
	logic [KEY_W-1:0] key_s1;
	logic             out_free;
	logic             advance;
	res_t             res;

	// Password registers and the clear pulse on writes.
	kcl_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.pw     (pw),
		.clear  (cfg_clear)
	);

	// Advance whenever a key waits and the result register can take its answer.
	assign advance = valid_s1 && out_free;

	kcl_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.keys     (keys),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.key_s1   (key_s1)
	);

	kcl_lock #(
		.MAX_KEYS (MAX_KEYS)
	) u_lock (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (cfg_clear),
		.step   (advance),
		.key_s1 (key_s1),
		.pw     (pw),
		.res    (res)
	);

	kcl_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (advance),
		.res     (res),
		.free    (out_free),
		.results (results)
	);

	// A decided key must show up as a pending result on the next cycle.
	`KCL_ASSERT_NEXT(a_advance_loads, advance, results.valid, "decided key left no result")
	// A correct password always reports the lock open.
	`KCL_ASSERT_NOW(a_correct_unlocks, results.valid && results.status == ST_CORRECT,
		results.unlocked, "correct password without unlocked flag")
	// Enter, correct or wrong, always leaves an empty entry and marks enter_seen.
	`KCL_ASSERT_NOW(a_enter_clears,
		results.valid && (results.status == ST_CORRECT || results.status == ST_WRONG),
		results.entry_count == '0 && results.enter_seen, "enter left keys or no enter mark")
	// A stored key never leaves the entry empty nor beyond its capacity.
	`KCL_ASSERT_NOW(a_stored_count, results.valid && results.status == ST_STORED,
		results.entry_count != '0 && results.entry_count <= CNT_W'(MAX_KEYS),
		"stored key with bad entry count")
endmodule
